// ===== rtl/lbfa_pkg.sv =====
package lbfa_pkg;

  localparam int MAX_BINS = 1024;
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int IDX_W = 10;
  localparam int BINS_CFG_W = 11;
  localparam int MAXB_W = $clog2(MAX_BINS + 1);
  localparam int NB_W = (MAXB_W > BINS_CFG_W) ? MAXB_W : BINS_CFG_W;
  localparam int ADDR_W = 5;
  localparam int DIV_BITS = 48;
  localparam int DIV_FIELDS = 5;
  localparam int PROJ_STEPS = 3;
  localparam int AX_STEPS = 6;

  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_INV_WIDTH = 3'd6;
  localparam logic [2:0] REG_BINS = 3'd7;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_READ = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NORM = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_PROJ, S_SCALE1, S_SCALE2, S_SCALE3, S_CHECK,
    S_RD, S_UPD, S_LOAD, S_DIVLD, S_DIVRUN, S_DIVST, S_WB, S_AX, S_WIPE, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_IDX,
    RES_BIN
  } res_t;

  typedef enum logic [1:0] {
    MS_DIFF,
    MS_FHI,
    MS_FLO
  } msrc_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0] inverse_bin_width;
    logic [BINS_CFG_W-1:0] bins_in_use;
  } cfg_t;

  typedef struct packed {
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
    logic signed [47:0] en;
    logic signed [47:0] vi;
    logic [31:0] cnt;
  } row_t;

  typedef struct packed {
    logic in_ready;
    logic item_load;
    logic b_from_idx;
    logic acc_clr;
    logic acc_add;
    logic mul_en;
    msrc_t mul_src;
    logic [1:0] mul_comp;
    logic sc1;
    logic sc2;
    logic sc3;
    logic row_add;
    logic row_load;
    logic div_load;
    logic div_step;
    logic div_store;
    logic [2:0] div_field;
    logic mem_we;
    logic wipe;
    logic [BIN_W-1:0] wipe_addr;
    logic out_load;
    res_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic idx_ok;
    logic hit;
    logic cnt_nz;
    logic out_full;
    kind_t kind;
  } status_t;

endpackage

// ===== rtl/lbfa_in_if.sv =====
interface lbfa_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] energy;
  logic signed [31:0] virial;
  logic with_virial;
  logic [9:0] bin_index;

  modport source (
    output valid, kind, pos_x, pos_y, pos_z, force_x, force_y, force_z, energy, virial,
    with_virial, bin_index,
    input ready
  );
  modport sink (
    input valid, kind, pos_x, pos_y, pos_z, force_x, force_y, force_z, energy, virial,
    with_virial, bin_index,
    output ready
  );
endinterface

// ===== rtl/lbfa_out_if.sv =====
interface lbfa_out_if;
  logic valid;
  logic ready;
  logic [9:0] out_bin;
  logic in_range;
  logic signed [47:0] sum_force_x;
  logic signed [47:0] sum_force_y;
  logic signed [47:0] sum_force_z;
  logic signed [47:0] sum_energy;
  logic signed [47:0] sum_virial;
  logic [31:0] sample_count;
  logic signed [47:0] axial_force;

  modport source (
    output valid, out_bin, in_range, sum_force_x, sum_force_y, sum_force_z, sum_energy,
    sum_virial, sample_count, axial_force,
    input ready
  );
  modport sink (
    input valid, out_bin, in_range, sum_force_x, sum_force_y, sum_force_z, sum_energy,
    sum_virial, sample_count, axial_force,
    output ready
  );
endinterface

// ===== rtl/line_binned_force_accumulator.sv =====
// Line-binned force accumulator. Each input word is one of four kinds: an add
// projects the sample position onto the configured line, picks its bin and adds
// force, energy, optional virial and one count to that bin with saturation; a
// read returns one bin; a clear zeroes every bin; a normalize divides one bin's
// sums by its count. A result word for a bin in range reports the bin's contents
// after the operation together with the force sum dotted with the line
// direction; other results are zero but for the bin index of a read or
// normalize that is out of range. The block takes one word at a time. Reads and
// adds are paced by the single shared 33x32 multiplier, which forms the three
// projection products and then the six partial products of the axial force,
// and by the bin memory with its one write port and registered read. A
// normalize adds the bit-serial divider, one quotient bit per cycle for each
// of five sums. A clear sweeps the memory one bin per cycle, and the same sweep
// runs over all MAX_BINS bins after reset before the first word is taken;
// configuration writes are taken throughout. A finished result waits in the
// output register, and the next word is accepted while it waits.
module line_binned_force_accumulator (
  input logic clk,
  input logic rst,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic [lbfa_pkg::ADDR_W-1:0] paddr,
  input logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  lbfa_in_if.sink in_ch,
  lbfa_out_if.source out_ch
);

  lbfa_pkg::cfg_t cfg;
  lbfa_pkg::cmd_t cmd;
  lbfa_pkg::status_t st;
  logic [2:0] reg_sel;
  logic wr_en;

  // Registers sit on 32-bit word boundaries; the low two address bits are ignored.
  assign reg_sel = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x <= '0;
      cfg.start_y <= '0;
      cfg.start_z <= '0;
      cfg.dir_x <= 32'sh4000_0000;
      cfg.dir_y <= '0;
      cfg.dir_z <= '0;
      cfg.inverse_bin_width <= 32'h0001_0000;
      cfg.bins_in_use <= lbfa_pkg::BINS_CFG_W'(1024);
    end else if (wr_en) begin
      case (reg_sel)
        lbfa_pkg::REG_START_X: cfg.start_x <= pwdata;
        lbfa_pkg::REG_START_Y: cfg.start_y <= pwdata;
        lbfa_pkg::REG_START_Z: cfg.start_z <= pwdata;
        lbfa_pkg::REG_DIR_X: cfg.dir_x <= pwdata;
        lbfa_pkg::REG_DIR_Y: cfg.dir_y <= pwdata;
        lbfa_pkg::REG_DIR_Z: cfg.dir_z <= pwdata;
        lbfa_pkg::REG_INV_WIDTH: cfg.inverse_bin_width <= pwdata;
        lbfa_pkg::REG_BINS: cfg.bins_in_use <= pwdata[lbfa_pkg::BINS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lbfa_pkg::REG_START_X: prdata = cfg.start_x;
      lbfa_pkg::REG_START_Y: prdata = cfg.start_y;
      lbfa_pkg::REG_START_Z: prdata = cfg.start_z;
      lbfa_pkg::REG_DIR_X: prdata = cfg.dir_x;
      lbfa_pkg::REG_DIR_Y: prdata = cfg.dir_y;
      lbfa_pkg::REG_DIR_Z: prdata = cfg.dir_z;
      lbfa_pkg::REG_INV_WIDTH: prdata = cfg.inverse_bin_width;
      lbfa_pkg::REG_BINS: prdata = 32'(cfg.bins_in_use);
      default: prdata = '0;
    endcase
  end

  // The controller sequences each word; the datapath holds the bin memory,
  // the shared multiplier, the divider and the output register.
  lbfa_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .st(st),
    .cmd(cmd)
  );

  lbfa_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd(cmd),
    .st(st),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

endmodule

// ===== rtl/lbfa_ctrl.sv =====
module lbfa_ctrl (
  input logic clk,
  input logic rst,
  input lbfa_pkg::status_t st,
  output lbfa_pkg::cmd_t cmd
);

  localparam logic [lbfa_pkg::BIN_W-1:0] SWEEP_LAST = lbfa_pkg::BIN_W'(lbfa_pkg::MAX_BINS - 1);
  localparam logic [5:0] DIV_LAST = 6'(lbfa_pkg::DIV_BITS - 1);
  localparam logic [2:0] FIELD_LAST = 3'(lbfa_pkg::DIV_FIELDS - 1);
  localparam logic [5:0] PROJ_LAST = 6'(lbfa_pkg::PROJ_STEPS);
  localparam logic [5:0] AX_LAST = 6'(lbfa_pkg::AX_STEPS);

  lbfa_pkg::state_t state, state_next;
  logic [5:0] step, step_next;
  logic [2:0] field, field_next;
  logic [lbfa_pkg::BIN_W-1:0] sweep, sweep_next;
  lbfa_pkg::res_t res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbfa_pkg::S_INIT;
      step <= '0;
      field <= '0;
      sweep <= '0;
      res <= lbfa_pkg::RES_ZERO;
    end else begin
      state <= state_next;
      step <= step_next;
      field <= field_next;
      sweep <= sweep_next;
      res <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    field_next = field;
    sweep_next = sweep;
    res_next = res;
    cmd = '0;
    cmd.wipe_addr = sweep;
    cmd.div_field = field;
    cmd.res_sel = res;
    cmd.mul_src = lbfa_pkg::MS_DIFF;
    cmd.mul_comp = step[1:0];
    case (state)
      lbfa_pkg::S_INIT: begin
        cmd.mem_we = 1'b1;
        cmd.wipe = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == SWEEP_LAST) begin
          state_next = lbfa_pkg::S_IDLE;
        end
      end
      lbfa_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.item_load = 1'b1;
          state_next = lbfa_pkg::S_DISPATCH;
        end
      end
      lbfa_pkg::S_DISPATCH: begin
        case (st.kind)
          lbfa_pkg::KIND_ADD: begin
            cmd.acc_clr = 1'b1;
            step_next = '0;
            state_next = lbfa_pkg::S_PROJ;
          end
          lbfa_pkg::KIND_CLEAR: begin
            sweep_next = '0;
            state_next = lbfa_pkg::S_WIPE;
          end
          default: begin
            if (st.idx_ok) begin
              cmd.b_from_idx = 1'b1;
              state_next = lbfa_pkg::S_RD;
            end else begin
              res_next = lbfa_pkg::RES_IDX;
              state_next = lbfa_pkg::S_DONE;
            end
          end
        endcase
      end
      lbfa_pkg::S_PROJ: begin
        cmd.mul_src = lbfa_pkg::MS_DIFF;
        cmd.mul_comp = step[1:0];
        cmd.mul_en = (step != PROJ_LAST);
        cmd.acc_add = (step != '0);
        step_next = step + 1'b1;
        if (step == PROJ_LAST) begin
          state_next = lbfa_pkg::S_SCALE1;
        end
      end
      lbfa_pkg::S_SCALE1: begin
        cmd.sc1 = 1'b1;
        state_next = lbfa_pkg::S_SCALE2;
      end
      lbfa_pkg::S_SCALE2: begin
        cmd.sc2 = 1'b1;
        state_next = lbfa_pkg::S_SCALE3;
      end
      lbfa_pkg::S_SCALE3: begin
        cmd.sc3 = 1'b1;
        state_next = lbfa_pkg::S_CHECK;
      end
      lbfa_pkg::S_CHECK: begin
        if (st.hit) begin
          state_next = lbfa_pkg::S_RD;
        end else begin
          res_next = lbfa_pkg::RES_ZERO;
          state_next = lbfa_pkg::S_DONE;
        end
      end
      lbfa_pkg::S_RD: begin
        if (st.kind == lbfa_pkg::KIND_ADD) begin
          state_next = lbfa_pkg::S_UPD;
        end else begin
          state_next = lbfa_pkg::S_LOAD;
        end
      end
      lbfa_pkg::S_UPD: begin
        cmd.row_add = 1'b1;
        state_next = lbfa_pkg::S_WB;
      end
      lbfa_pkg::S_LOAD: begin
        cmd.row_load = 1'b1;
        if (st.kind == lbfa_pkg::KIND_NORM && st.cnt_nz) begin
          field_next = '0;
          state_next = lbfa_pkg::S_DIVLD;
        end else begin
          cmd.acc_clr = 1'b1;
          step_next = '0;
          state_next = lbfa_pkg::S_AX;
        end
      end
      lbfa_pkg::S_DIVLD: begin
        cmd.div_load = 1'b1;
        step_next = '0;
        state_next = lbfa_pkg::S_DIVRUN;
      end
      lbfa_pkg::S_DIVRUN: begin
        cmd.div_step = 1'b1;
        step_next = step + 1'b1;
        if (step == DIV_LAST) begin
          state_next = lbfa_pkg::S_DIVST;
        end
      end
      lbfa_pkg::S_DIVST: begin
        cmd.div_store = 1'b1;
        if (field == FIELD_LAST) begin
          state_next = lbfa_pkg::S_WB;
        end else begin
          field_next = field + 1'b1;
          state_next = lbfa_pkg::S_DIVLD;
        end
      end
      lbfa_pkg::S_WB: begin
        cmd.mem_we = 1'b1;
        cmd.acc_clr = 1'b1;
        step_next = '0;
        state_next = lbfa_pkg::S_AX;
      end
      lbfa_pkg::S_AX: begin
        cmd.mul_src = step[0] ? lbfa_pkg::MS_FLO : lbfa_pkg::MS_FHI;
        cmd.mul_comp = step[2:1];
        cmd.mul_en = (step != AX_LAST);
        cmd.acc_add = (step != '0);
        step_next = step + 1'b1;
        if (step == AX_LAST) begin
          res_next = lbfa_pkg::RES_BIN;
          state_next = lbfa_pkg::S_DONE;
        end
      end
      lbfa_pkg::S_WIPE: begin
        cmd.mem_we = 1'b1;
        cmd.wipe = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == SWEEP_LAST) begin
          res_next = lbfa_pkg::RES_ZERO;
          state_next = lbfa_pkg::S_DONE;
        end
      end
      lbfa_pkg::S_DONE: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          state_next = lbfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lbfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lbfa_datapath.sv =====
module lbfa_datapath (
  input logic clk,
  input logic rst,
  input lbfa_pkg::cfg_t cfg,
  input lbfa_pkg::cmd_t cmd,
  output lbfa_pkg::status_t st,
  lbfa_in_if.sink in_ch,
  lbfa_out_if.source out_ch
);

  // Captured input word.
  lbfa_pkg::kind_t item_kind;
  logic signed [31:0] item_pos_x, item_pos_y, item_pos_z;
  logic signed [31:0] item_fx, item_fy, item_fz, item_en, item_vi;
  logic item_with_virial;
  logic [lbfa_pkg::IDX_W-1:0] item_idx;

  lbfa_pkg::row_t mem [lbfa_pkg::MAX_BINS];
  lbfa_pkg::row_t rd_row, wrow, add_row, wr_data;
  logic [lbfa_pkg::BIN_W-1:0] b, wr_addr;
  logic [lbfa_pkg::NB_W-1:0] nb;

  logic signed [32:0] diff_x, diff_y, diff_z, diff_sel, mul_a;
  logic signed [31:0] dir_sel;
  logic signed [47:0] f_sel;
  logic signed [64:0] p;
  logic p_hi;
  logic signed [81:0] acc;

  logic signed [36:0] proj;
  logic [36:0] m, q;
  logic neg;
  logic [52:0] qa, qb, qsum;
  logic hit;

  logic signed [47:0] div_src;
  logic dneg;
  logic [47:0] dq;
  logic [31:0] drem;
  logic [32:0] trial;
  logic take;
  logic signed [47:0] dres;

  logic signed [51:0] ax_full;
  logic signed [47:0] ax_sat;

  logic out_valid;
  logic [lbfa_pkg::IDX_W-1:0] o_bin;
  logic o_in_range;
  logic signed [47:0] o_fx, o_fy, o_fz, o_en, o_vi, o_ax;
  logic [31:0] o_cnt;

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
                                                 input logic signed [31:0] v);
    logic signed [48:0] t;
    t = 49'(s) + 49'(v);
    if (t > 49'(lbfa_pkg::S48_MAX)) begin
      return lbfa_pkg::S48_MAX;
    end else if (t < 49'(lbfa_pkg::S48_MIN)) begin
      return lbfa_pkg::S48_MIN;
    end
    return 48'(t);
  endfunction

  assign nb = (lbfa_pkg::NB_W'(cfg.bins_in_use) < lbfa_pkg::NB_W'(lbfa_pkg::MAX_BINS)) ?
              lbfa_pkg::NB_W'(cfg.bins_in_use) : lbfa_pkg::NB_W'(lbfa_pkg::MAX_BINS);

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_kind <= lbfa_pkg::kind_t'(in_ch.kind);
      item_pos_x <= in_ch.pos_x;
      item_pos_y <= in_ch.pos_y;
      item_pos_z <= in_ch.pos_z;
      item_fx <= in_ch.force_x;
      item_fy <= in_ch.force_y;
      item_fz <= in_ch.force_z;
      item_en <= in_ch.energy;
      item_vi <= in_ch.virial;
      item_with_virial <= in_ch.with_virial;
      item_idx <= in_ch.bin_index;
    end
  end

  // Shared multiplier: position offsets for the projection, then split force sums
  // for the axial force.
  assign diff_x = 33'(item_pos_x) - 33'(cfg.start_x);
  assign diff_y = 33'(item_pos_y) - 33'(cfg.start_y);
  assign diff_z = 33'(item_pos_z) - 33'(cfg.start_z);

  always_comb begin
    case (cmd.mul_comp)
      2'd0: begin
        diff_sel = diff_x;
        dir_sel = cfg.dir_x;
        f_sel = wrow.fx;
      end
      2'd1: begin
        diff_sel = diff_y;
        dir_sel = cfg.dir_y;
        f_sel = wrow.fy;
      end
      default: begin
        diff_sel = diff_z;
        dir_sel = cfg.dir_z;
        f_sel = wrow.fz;
      end
    endcase
    case (cmd.mul_src)
      lbfa_pkg::MS_FHI: mul_a = 33'(f_sel >>> 24);
      lbfa_pkg::MS_FLO: mul_a = {9'd0, f_sel[23:0]};
      default: mul_a = diff_sel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p <= 65'(mul_a) * 65'(dir_sel);
      p_hi <= (cmd.mul_src == lbfa_pkg::MS_FHI);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + (p_hi ? (82'(p) <<< 24) : 82'(p));
    end
  end

  // Bin from the projection: trunc(|proj| * inverse width / 2^32).
  assign proj = 37'(acc >>> 30);
  assign qsum = qa + (qb >> 16);
  assign q = 37'(qsum >> 16);

  always_ff @(posedge clk) begin
    if (cmd.sc1) begin
      neg <= proj[36];
      m <= proj[36] ? 37'(-proj) : 37'(proj);
    end
    if (cmd.sc2) begin
      qa <= 53'(m) * 53'(cfg.inverse_bin_width[31:16]);
      qb <= 53'(m) * 53'(cfg.inverse_bin_width[15:0]);
    end
    if (cmd.sc3) begin
      hit <= (cfg.inverse_bin_width != '0) && !(neg && q != '0) && (q < 37'(nb));
      b <= lbfa_pkg::BIN_W'(q);
    end else if (cmd.b_from_idx) begin
      b <= lbfa_pkg::BIN_W'(item_idx);
    end
  end

  // Bin store: one write port, one registered read port.
  assign wr_addr = cmd.wipe ? cmd.wipe_addr : b;
  assign wr_data = cmd.wipe ? '0 : wrow;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_row <= mem[b];
  end

  always_comb begin
    add_row.fx = sat_add(rd_row.fx, item_fx);
    add_row.fy = sat_add(rd_row.fy, item_fy);
    add_row.fz = sat_add(rd_row.fz, item_fz);
    add_row.en = sat_add(rd_row.en, item_en);
    add_row.vi = item_with_virial ? sat_add(rd_row.vi, item_vi) : rd_row.vi;
    add_row.cnt = (rd_row.cnt == '1) ? rd_row.cnt : rd_row.cnt + 32'd1;
  end

  // Bit-serial divider, one quotient bit per cycle on the sum magnitude.
  always_comb begin
    case (cmd.div_field)
      3'd0: div_src = wrow.fx;
      3'd1: div_src = wrow.fy;
      3'd2: div_src = wrow.fz;
      3'd3: div_src = wrow.en;
      default: div_src = wrow.vi;
    endcase
  end

  assign trial = {drem, dq[47]};
  assign take = (trial >= {1'b0, wrow.cnt});
  assign dres = dneg ? -$signed(dq) : $signed(dq);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dneg <= div_src[47];
      dq <= div_src[47] ? 48'(-div_src) : 48'(div_src);
      drem <= '0;
    end else if (cmd.div_step) begin
      drem <= take ? 32'(trial - {1'b0, wrow.cnt}) : trial[31:0];
      dq <= {dq[46:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_add) begin
      wrow <= add_row;
    end else if (cmd.row_load) begin
      wrow <= rd_row;
    end else if (cmd.div_store) begin
      case (cmd.div_field)
        3'd0: wrow.fx <= dres;
        3'd1: wrow.fy <= dres;
        3'd2: wrow.fz <= dres;
        3'd3: wrow.en <= dres;
        default: wrow.vi <= dres;
      endcase
    end
  end

  assign ax_full = 52'(acc >>> 30);
  assign ax_sat = (ax_full > 52'(lbfa_pkg::S48_MAX)) ? lbfa_pkg::S48_MAX :
                  (ax_full < 52'(lbfa_pkg::S48_MIN)) ? lbfa_pkg::S48_MIN : 48'(ax_full);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_bin <= '0;
      o_in_range <= 1'b0;
      o_fx <= '0;
      o_fy <= '0;
      o_fz <= '0;
      o_en <= '0;
      o_vi <= '0;
      o_cnt <= '0;
      o_ax <= '0;
      case (cmd.res_sel)
        lbfa_pkg::RES_IDX: begin
          o_bin <= item_idx;
        end
        lbfa_pkg::RES_BIN: begin
          o_bin <= lbfa_pkg::IDX_W'(b);
          o_in_range <= 1'b1;
          o_fx <= wrow.fx;
          o_fy <= wrow.fy;
          o_fz <= wrow.fz;
          o_en <= wrow.en;
          o_vi <= wrow.vi;
          o_cnt <= wrow.cnt;
          o_ax <= ax_sat;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = cmd.in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.out_bin = o_bin;
  assign out_ch.in_range = o_in_range;
  assign out_ch.sum_force_x = o_fx;
  assign out_ch.sum_force_y = o_fy;
  assign out_ch.sum_force_z = o_fz;
  assign out_ch.sum_energy = o_en;
  assign out_ch.sum_virial = o_vi;
  assign out_ch.sample_count = o_cnt;
  assign out_ch.axial_force = o_ax;

  assign st.in_valid = in_ch.valid;
  assign st.idx_ok = (lbfa_pkg::NB_W'(item_idx) < nb);
  assign st.hit = hit;
  assign st.cnt_nz = (rd_row.cnt != '0);
  assign st.out_full = out_valid && !out_ch.ready;
  assign st.kind = item_kind;

  a_write_active_bin: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we && !cmd.wipe |-> lbfa_pkg::NB_W'(b) < nb)
    else $error("bin row written outside the active bins");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ch.ready))
    else $error("result word loaded over one not yet taken");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.row_add |=> (wrow.cnt == $past(rd_row.cnt) + 32'd1) || ($past(rd_row.cnt) == '1))
    else $error("sample count did not advance by one");

endmodule
